// ----- sv/kts_pkg.sv -----
// kts_pkg: shared types and constants for the key/ttl command scanner
// used by kts_eval and key_ttl_command_scanner; no dependencies
`default_nettype none

package kts_pkg;

	// field widths
	localparam int unsigned TICK_W   = 32;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned HOLD_W   = 8;
	localparam int unsigned CFG_W    = 16;

	// stream payload widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 8;

	// register reset values
	localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST = PERIOD_W'(100);
	localparam logic [HOLD_W-1:0]   HOLD_SAMPLES_RST = HOLD_W'(100);

	// register indexes
	typedef enum logic {
		REG_POLL_PERIOD  = 1'b0,
		REG_HOLD_SAMPLES = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KEY_NONE       = 2'd0,
		KEY_CALIBRATE  = 2'd1,
		KEY_FULL_OPEN  = 2'd2,
		KEY_FULL_CLOSE = 2'd3
	} key_cmd_t;

	typedef enum logic [1:0] {
		LOCK_NONE  = 2'd0,
		LOCK_SET   = 2'd1,
		LOCK_CLEAR = 2'd2
	} lock_cmd_t;

	// input item, now_tick in the lowest bits
	typedef struct packed {
		logic              lock_line_level;
		logic              close_key_level;
		logic              open_key_level;
		logic [TICK_W-1:0] now_tick;
	} kts_item_t;

	// result item, sampled in the lowest bit
	typedef struct packed {
		lock_cmd_t lock_command;
		key_cmd_t  key_command;
		logic      sampled;
	} kts_result_t;

	localparam int unsigned ITEM_W   = $bits(kts_item_t);
	localparam int unsigned RESULT_W = $bits(kts_result_t);

endpackage

`default_nettype wire

// ----- sv/kts_eval.sv -----
// kts_eval: sampling state and command rules for one item
// depends on kts_pkg
`default_nettype none

module kts_eval
	import kts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire kts_item_t           item,
	input  wire logic [PERIOD_W-1:0] poll_period,
	input  wire logic [HOLD_W-1:0]   hold_samples,
	output kts_result_t              result
);

	logic [TICK_W-1:0] last_tick_q;
	logic              prev_open_q;
	logic              prev_close_q;
	logic              prev_lock_q;
	logic [HOLD_W-1:0] count_q;

	logic [TICK_W-1:0] elapsed;
	logic              do_sample;
	logic              both_down;
	logic [HOLD_W-1:0] count_inc;
	logic              calib;

	logic              prev_open_d;
	logic              prev_close_d;
	logic              prev_lock_d;
	logic [HOLD_W-1:0] count_d;

	// wrap-safe elapsed time against the poll period
	assign elapsed   = item.now_tick - last_tick_q;
	assign do_sample = elapsed >= {{(TICK_W-PERIOD_W){1'b0}}, poll_period};
	assign both_down = !item.open_key_level && !item.close_key_level;
	assign count_inc = count_q + HOLD_W'(1);
	assign calib     = count_inc >= hold_samples;

	// key and lock rules
	always_comb begin
		result       = '{lock_command: LOCK_NONE, key_command: KEY_NONE, sampled: 1'b0};
		prev_open_d  = prev_open_q;
		prev_close_d = prev_close_q;
		prev_lock_d  = prev_lock_q;
		count_d      = '0;
		if (do_sample) begin
			result.sampled = 1'b1;
			if (both_down) begin
				if (calib) begin
					result.key_command = KEY_CALIBRATE;
				end else begin
					count_d = count_inc;
				end
				prev_open_d  = 1'b0;
				prev_close_d = 1'b0;
			end else if (item.open_key_level != prev_open_q) begin
				if (!item.open_key_level) begin
					result.key_command = KEY_FULL_OPEN;
				end
				prev_open_d = item.open_key_level;
			end else if (item.close_key_level != prev_close_q) begin
				if (!item.close_key_level) begin
					result.key_command = KEY_FULL_CLOSE;
				end
				prev_close_d = item.close_key_level;
			end
			if (item.lock_line_level) begin
				result.lock_command = LOCK_SET;
				prev_lock_d         = 1'b1;
			end else if (prev_lock_q) begin
				result.lock_command = LOCK_CLEAR;
				prev_lock_d         = 1'b0;
			end
		end
	end

	// state moves only on a sampled item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q  <= '0;
			prev_open_q  <= 1'b0;
			prev_close_q <= 1'b0;
			prev_lock_q  <= 1'b1;
			count_q      <= '0;
		end else if (step && do_sample) begin
			last_tick_q  <= item.now_tick;
			prev_open_q  <= prev_open_d;
			prev_close_q <= prev_close_d;
			prev_lock_q  <= prev_lock_d;
			count_q      <= count_d;
		end
	end

	// calibrate only when both keys are down
	a_calib_both_down: assert property (@(posedge clk) disable iff (!arst_n)
		result.key_command == KEY_CALIBRATE |-> both_down)
		else $error("calibrate without both keys down");

	// a sampled item stores its tick
	a_tick_stored: assert property (@(posedge clk) disable iff (!arst_n)
		step && do_sample |=> last_tick_q == $past(item.now_tick))
		else $error("sample tick not stored");

	// calibrate restarts the hold count
	a_calib_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.key_command == KEY_CALIBRATE |=> count_q == '0)
		else $error("hold count not cleared after calibrate");

	// no command on an item that is not sampled
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!result.sampled |-> result.key_command == KEY_NONE
			&& result.lock_command == LOCK_NONE)
		else $error("command without a sample");

endmodule

`default_nettype wire

// ----- sv/key_ttl_command_scanner.sv -----
// key_ttl_command_scanner: top level with config registers, input and output stages
// depends on kts_pkg and kts_eval
// path: an accepted item enters the input stage, then its result the result stage
// throughput: one item per cycle while the result register is not stalled by m_tready;
// the rules and the state update sit in one stage
// stall: the input stage holds while the result register waits on m_tready
// reset: arst_n clears pipeline and sampling state; sets prev lock, both registers to 100
`default_nettype none

module key_ttl_command_scanner
	import kts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tdata: now_tick[31:0], open_key_level[32], close_key_level[33], lock_line_level[34]
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// tdata: sampled[0], key_command[2:1], lock_command[4:3]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	logic [PERIOD_W-1:0] poll_period_q;
	logic [HOLD_W-1:0]   hold_samples_q;

	logic        valid_s1;
	kts_item_t   item_s1;
	logic        valid_s2;
	kts_result_t result_s2;
	kts_result_t result;
	logic        advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q  <= POLL_PERIOD_RST;
			hold_samples_q <= HOLD_SAMPLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POLL_PERIOD:  poll_period_q  <= cfg_data[PERIOD_W-1:0];
				REG_HOLD_SAMPLES: hold_samples_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= kts_item_t'(s_tdata[ITEM_W-1:0]);
		end
	end

	kts_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.poll_period  (poll_period_q),
		.hold_samples (hold_samples_q),
		.result       (result)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, result_s2};

	// a stalled result is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !advance)
		else $error("result overwritten while stalled");

	// input is refused only while the input stage holds an item and the result stage is stalled
	a_ready_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input refused without a stall");

	// an advancing item shows as a result next cycle
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item lost");

endmodule

`default_nettype wire
